>>> rtl/fsd_pkg.sv
`timescale 1ns / 1ps

package fsd_pkg;

	localparam int ERR_W = 14;
	localparam int CFG_W = 11;
	localparam int GRAY_W = 8;
	localparam int MAX_WIDTH_DEF = 1024;

	localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 11'd384;
	localparam logic [GRAY_W-1:0] THRESHOLD_RST = 8'd128;

	localparam logic signed [ERR_W:0] Q4_WHITE = 15'sd4080;
	localparam logic signed [ERR_W-1:0] SAT_HI = 14'sh1fff;
	localparam logic signed [ERR_W-1:0] SAT_LO = 14'sh2000;

	typedef logic signed [ERR_W-1:0] err_t;

	typedef enum logic [0:0] {
		CFG_LINE_WIDTH = 1'b0,
		CFG_THRESHOLD  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [GRAY_W-1:0] gray;
		logic              fs;
		logic              first;
		logic              last;
		logic              has_left;
	} pix_ctl_t;

	typedef struct packed {
		logic left_en;
		logic here_en;
		err_t left_data;
		err_t here_data;
	} wr_req_t;

	function automatic err_t sat14(input logic signed [16:0] x);
		err_t r;
		if (x > 17'sd8191) begin
			r = SAT_HI;
		end else if (x < -17'sd8192) begin
			r = SAT_LO;
		end else begin
			r = x[ERR_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/fsd_pix_if.sv
`timescale 1ns / 1ps

interface fsd_pix_if;
	logic                           valid;
	logic                           ready;
	logic [fsd_pkg::GRAY_W-1:0]     gray;
	logic                           frame_start;

	modport source (output valid, gray, frame_start, input ready);
	modport sink (input valid, gray, frame_start, output ready);
endinterface

>>> rtl/fsd_res_if.sv
`timescale 1ns / 1ps

interface fsd_res_if;
	logic valid;
	logic ready;
	logic white;
	logic row_end;

	modport source (output valid, white, row_end, input ready);
	modport sink (input valid, white, row_end, output ready);
endinterface

>>> rtl/fsd_ram.sv
`timescale 1ns / 1ps

module fsd_ram #(
	parameter int WIDTH = fsd_pkg::ERR_W,
	parameter int DEPTH = fsd_pkg::MAX_WIDTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/fsd_line_store.sv
`timescale 1ns / 1ps

module fsd_line_store #(
	parameter int MAX_WIDTH = fsd_pkg::MAX_WIDTH_DEF,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [CW-1:0]    rd_addr,
	output fsd_pkg::err_t    rd_data,
	input  logic             commit,
	input  logic [CW-1:0]    col,
	input  fsd_pkg::wr_req_t wr
);

	logic                    commit_left;
	logic                    commit_here;
	logic                    ram_we;
	logic [CW-1:0]           ram_waddr;
	fsd_pkg::err_t           ram_wdata;
	logic [fsd_pkg::ERR_W-1:0] ram_rdata;
	logic                    pend_q;
	logic [CW-1:0]           pend_addr_q;
	fsd_pkg::err_t           pend_data_q;
	logic                    fwd_q;
	fsd_pkg::err_t           fwd_data_q;

	assign commit_left = commit && wr.left_en;
	assign commit_here = commit && wr.here_en;

	// The last pixel of a row writes two entries; the second waits in the pending
	// register until a cycle with no other write. Only a row one pixel wide can keep
	// it waiting, and such a row never writes below-left.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = col;
		ram_wdata = wr.here_data;
		if (commit_left) begin
			ram_we    = 1'b1;
			ram_waddr = col - CW'(1);
			ram_wdata = wr.left_data;
		end else if (commit_here) begin
			ram_we    = 1'b1;
		end else if (pend_q) begin
			ram_we    = 1'b1;
			ram_waddr = pend_addr_q;
			ram_wdata = pend_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			fwd_q  <= 1'b0;
		end else begin
			if (commit_left && commit_here) begin
				pend_q <= 1'b1;
			end else if (!commit_left && !commit_here) begin
				pend_q <= 1'b0;
			end
			if (rd_en) begin
				fwd_q <= ram_we && (ram_waddr == rd_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit_left && commit_here) begin
			pend_addr_q <= col;
			pend_data_q <= wr.here_data;
		end
		if (rd_en) begin
			fwd_data_q <= ram_wdata;
		end
	end

	fsd_ram #(
		.WIDTH (fsd_pkg::ERR_W),
		.DEPTH (MAX_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign rd_data = fwd_q ? fwd_data_q : fsd_pkg::err_t'(ram_rdata);

	a_pend_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && !commit_here |=> !pend_q)
		else $error("pending line store write not drained");

	a_left_not_col0: assert property (@(posedge clk) disable iff (!arst_n)
		commit_left |-> col != '0)
		else $error("below-left write on the first column");

endmodule

>>> rtl/fsd_diffuse.sv
`timescale 1ns / 1ps

module fsd_diffuse (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         commit,
	input  fsd_pkg::pix_ctl_t            ctl,
	input  logic [fsd_pkg::GRAY_W-1:0]   threshold,
	input  fsd_pkg::err_t                below,
	output logic                         white,
	output fsd_pkg::wr_req_t             wr
);

	fsd_pkg::err_t           right_error_q;
	fsd_pkg::err_t           bp0_q;
	fsd_pkg::err_t           bp1_q;
	fsd_pkg::err_t           re_eff;
	fsd_pkg::err_t           p0_eff;
	fsd_pkg::err_t           p1_eff;
	fsd_pkg::err_t           bl_eff;
	logic signed [16:0]      sum;
	fsd_pkg::err_t           v;
	fsd_pkg::err_t           thr_q4;
	logic signed [14:0]      e;
	logic signed [17:0]      ex;
	logic signed [17:0]      e3;
	logic signed [17:0]      e5;
	logic signed [17:0]      e7;
	fsd_pkg::err_t           s3;
	fsd_pkg::err_t           s5;
	fsd_pkg::err_t           s7;
	fsd_pkg::err_t           s1;
	fsd_pkg::err_t           left_sum;
	fsd_pkg::err_t           nb0;

	// A frame start clears the carries before this pixel uses them.
	assign re_eff = ctl.fs ? '0 : right_error_q;
	assign p0_eff = ctl.fs ? '0 : bp0_q;
	assign p1_eff = ctl.fs ? '0 : bp1_q;
	assign bl_eff = ctl.first ? '0 : below;

	assign sum = $signed({5'b00000, ctl.gray, 4'b0000})
		+ $signed({{3{re_eff[13]}}, re_eff})
		+ $signed({{3{bl_eff[13]}}, bl_eff});
	assign v = fsd_pkg::sat14(sum);

	assign thr_q4 = $signed({2'b00, threshold, 4'b0000});
	assign white  = (v >= thr_q4);
	assign e      = $signed({v[13], v}) - (white ? fsd_pkg::Q4_WHITE : 15'sd0);

	// Shares are floored by an arithmetic shift of the scaled error.
	assign ex = $signed({{3{e[14]}}, e});
	assign e3 = (ex <<< 1) + ex;
	assign e5 = (ex <<< 2) + ex;
	assign e7 = (ex <<< 3) - ex;
	assign s3 = e3[17:4];
	assign s5 = e5[17:4];
	assign s7 = e7[17:4];
	assign s1 = $signed({{3{e[14]}}, e[14:4]});

	assign left_sum = fsd_pkg::sat14($signed({{3{p0_eff[13]}}, p0_eff})
		+ $signed({{3{s3[13]}}, s3}));
	assign nb0 = fsd_pkg::sat14($signed({{3{p1_eff[13]}}, p1_eff})
		+ $signed({{3{s5[13]}}, s5}));

	assign wr.left_en   = ctl.has_left;
	assign wr.here_en   = ctl.last;
	assign wr.left_data = left_sum;
	assign wr.here_data = nb0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_error_q <= '0;
			bp0_q         <= '0;
			bp1_q         <= '0;
		end else if (commit) begin
			if (ctl.last) begin
				right_error_q <= '0;
				bp0_q         <= '0;
				bp1_q         <= '0;
			end else begin
				right_error_q <= s7;
				bp0_q         <= nb0;
				bp1_q         <= s1;
			end
		end
	end

	a_row_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		commit && ctl.last |=> right_error_q == '0 && bp0_q == '0 && bp1_q == '0)
		else $error("error carries not cleared at row end");

endmodule

>>> rtl/floyd_steinberg_dither.sv
// Pipeline: an accepted pixel is registered in s1, where the line store read returns and
// the error is diffused; its result is registered in s2, which drives the result port.
// Throughput: one pixel per cycle unless res.ready stalls; the right-error carry is
// one add, compare and shift-add per cycle; the line store takes one read and one write per cycle.
// Reset: asynchronous, active low; clears the handshake, column and error carries,
// sets line_width to 384 and threshold to 128. The line store is not cleared.
`timescale 1ns / 1ps

module floyd_steinberg_dither #(
	parameter int MAX_WIDTH = fsd_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fsd_pix_if.sink                     pix,
	fsd_res_if.source                   res,
	input  logic                        cfg_wr_en,
	input  fsd_pkg::cfg_idx_t           cfg_index,
	input  logic [fsd_pkg::CFG_W-1:0]   cfg_wr_data
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int LW = (CW + 1 > fsd_pkg::CFG_W) ? CW + 1 : fsd_pkg::CFG_W;

	logic [fsd_pkg::CFG_W-1:0]  line_width_q;
	logic [fsd_pkg::GRAY_W-1:0] threshold_q;
	logic [LW-1:0]              lw_ext;
	logic [LW-1:0]              w_eff;
	logic [CW-1:0]              column_q;
	logic                       first_row_q;
	logic [CW-1:0]              acc_col;
	logic                       acc_first;
	logic                       acc_last;
	logic                       pix_acc;
	logic                       valid_s1;
	fsd_pkg::pix_ctl_t          ctl_s1;
	logic [CW-1:0]              col_s1;
	logic                       s1_adv;
	logic                       valid_s2;
	logic                       white_s2;
	logic                       row_end_s2;
	fsd_pkg::err_t              below;
	logic                       white;
	fsd_pkg::wr_req_t           wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= fsd_pkg::LINE_WIDTH_RST;
			threshold_q  <= fsd_pkg::THRESHOLD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fsd_pkg::CFG_LINE_WIDTH: begin
					line_width_q <= cfg_wr_data;
				end
				fsd_pkg::CFG_THRESHOLD: begin
					threshold_q <= cfg_wr_data[fsd_pkg::GRAY_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign lw_ext = LW'(line_width_q);

	always_comb begin
		w_eff = lw_ext;
		if (lw_ext == '0) begin
			w_eff = LW'(1);
		end else if (lw_ext > LW'(MAX_WIDTH)) begin
			w_eff = LW'(MAX_WIDTH);
		end
	end

	assign pix_acc   = pix.valid && pix.ready;
	assign acc_col   = pix.frame_start ? '0 : column_q;
	assign acc_first = pix.frame_start || first_row_q;
	assign acc_last  = (LW'(acc_col) + LW'(1)) >= w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			first_row_q <= 1'b1;
		end else if (pix_acc) begin
			if (acc_last) begin
				column_q    <= '0;
				first_row_q <= 1'b0;
			end else begin
				column_q    <= acc_col + CW'(1);
				first_row_q <= acc_first;
			end
		end
	end

	assign s1_adv    = valid_s1 && (!valid_s2 || res.ready);
	assign pix.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			ctl_s1.gray     <= pix.gray;
			ctl_s1.fs       <= pix.frame_start;
			ctl_s1.first    <= acc_first;
			ctl_s1.last     <= acc_last;
			ctl_s1.has_left <= (acc_col != '0);
			col_s1          <= acc_col;
		end
	end

	fsd_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (pix_acc),
		.rd_addr (acc_col),
		.rd_data (below),
		.commit  (s1_adv),
		.col     (col_s1),
		.wr      (wr)
	);

	fsd_diffuse u_diffuse (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (s1_adv),
		.ctl       (ctl_s1),
		.threshold (threshold_q),
		.below     (below),
		.white     (white),
		.wr        (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			white_s2   <= white;
			row_end_s2 <= ctl_s1.last;
		end
	end

	assign res.valid   = valid_s2;
	assign res.white   = white_s2;
	assign res.row_end = row_end_s2;

	a_row_end_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && acc_last |=> column_q == '0 && !first_row_q)
		else $error("column not wrapped after the last pixel of a row");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(col_s1))
		else $error("stalled pixel lost its column");

endmodule

>>> sim/floyd_steinberg_dither_tb.sv
`timescale 1ns / 1ps

module floyd_steinberg_dither_tb;

	localparam int DEPTH = fsd_pkg::MAX_WIDTH_DEF;
	localparam int COL_W = $clog2(DEPTH);
	localparam int GRAY_W = fsd_pkg::GRAY_W;
	localparam int CFG_W = fsd_pkg::CFG_W;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int Q4_FULL = 4080;

	typedef struct packed {
		logic white;
		logic row_end;
	} dot_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	fsd_pkg::cfg_idx_t cfg_index;
	logic [CFG_W-1:0] cfg_wr_data;

	fsd_pix_if pix_ch ();
	fsd_res_if res_ch ();

	floyd_steinberg_dither #(.MAX_WIDTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_ch),
		.res(res_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	logic [CFG_W-1:0] width_reg = fsd_pkg::LINE_WIDTH_RST;
	logic [GRAY_W-1:0] thresh_reg = fsd_pkg::THRESHOLD_RST;
	logic [COL_W-1:0] col_q = '0;
	logic top_row = 1'b1;
	fsd_pkg::err_t carry_right = '0;
	fsd_pkg::err_t part_left = '0;
	fsd_pkg::err_t part_here = '0;
	fsd_pkg::err_t err_store [DEPTH];
	bit stored [DEPTH];
	dot_t expected_dots [$];

	bit src_steady = 1'b0;
	bit sink_steady = 1'b0;
	int stall_left = 0;
	int cycles = 0;
	int faults = 0;
	int n_pixels = 0;
	int n_frames = 0;
	int n_results = 0;
	int n_cfg = 0;

	function automatic fsd_pkg::err_t clamp_err(input int x);
		if (x > 8191) begin
			return fsd_pkg::err_t'(8191);
		end
		if (x < -8192) begin
			return fsd_pkg::err_t'(-8192);
		end
		return fsd_pkg::err_t'(x);
	endfunction

	function automatic dot_t diffuse_pixel(input logic [GRAY_W-1:0] g,
		input logic fs);
		int w;
		int col;
		int below;
		int v;
		int e;
		int down;
		dot_t d;
		if (fs) begin
			col_q = '0;
			top_row = 1'b1;
			carry_right = '0;
			part_left = '0;
			part_here = '0;
		end
		w = int'(width_reg);
		if (w == 0) begin
			w = 1;
		end
		if (w > DEPTH) begin
			w = DEPTH;
		end
		col = int'(col_q);
		d.row_end = (col + 1 >= w);
		below = top_row ? 0 : int'(err_store[col]);
		v = int'(clamp_err(int'(g) * 16 + int'(carry_right) + below));
		d.white = (v >= int'(thresh_reg) * 16);
		e = v - (d.white ? Q4_FULL : 0);
		if (col > 0) begin
			err_store[col-1] = clamp_err(int'(part_left) + ((e * 3) >>> 4));
			stored[col-1] = 1'b1;
		end
		down = int'(clamp_err(int'(part_here) + ((e * 5) >>> 4)));
		if (d.row_end) begin
			err_store[col] = fsd_pkg::err_t'(down);
			stored[col] = 1'b1;
			part_left = '0;
			part_here = '0;
			carry_right = '0;
			col_q = '0;
			top_row = 1'b0;
		end else begin
			part_left = fsd_pkg::err_t'(down);
			part_here = fsd_pkg::err_t'(e >>> 4);
			carry_right = fsd_pkg::err_t'((e * 7) >>> 4);
			col_q = col_q + 1'b1;
		end
		return d;
	endfunction

	// The line store is not cleared by reset, so a pixel that would read an
	// entry never written is turned into the start of a new frame instead.
	function automatic bit reads_blank(input logic fs);
		if (fs || top_row) begin
			return 1'b0;
		end
		return !stored[col_q];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [GRAY_W-1:0] pick_gray(input int mode,
		input logic [GRAY_W-1:0] prev);
		int t;
		case (mode)
			0: begin
				return GRAY_W'($urandom_range(0, 255));
			end
			1: begin
				t = int'(prev) + int'($urandom_range(0, 8)) - 4;
				if (t < 0) begin
					t = 0;
				end
				if (t > 255) begin
					t = 255;
				end
				return GRAY_W'(t);
			end
			2: begin
				return $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			default: begin
				return ($urandom_range(0, 9) == 0) ? GRAY_W'($urandom_range(0, 255)) : prev;
			end
		endcase
	endfunction

	task automatic note_fault(input string what, input dot_t want, input dot_t got);
		faults++;
		if (faults <= 10) begin
			$display("mismatch at cycle %0d: %s: expected white=%0b row_end=%0b,",
				cycles, what, want.white, want.row_end);
			$display("    got white=%0b row_end=%0b", got.white, got.row_end);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results pending",
				cycles, expected_dots.size());
			$display("floyd_steinberg_dither_tb: errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			res_ch.ready <= 1'b1;
			stall_left = sink_steady ? 0 : pick_gap();
		end
	end

	always @(posedge clk) begin
		dot_t got;
		dot_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.white, res_ch.row_end};
			n_results++;
			if (expected_dots.size() == 0) begin
				note_fault("result with no pixel pending", '0, got);
			end else begin
				want = expected_dots.pop_front();
				if (got.white !== want.white) begin
					note_fault("white", want, got);
				end else if (got.row_end !== want.row_end) begin
					note_fault("row_end", want, got);
				end
			end
		end
	end

	task automatic send_pixel(input logic [GRAY_W-1:0] g, input logic fs);
		int gap;
		logic fs_eff;
		dot_t d;
		gap = src_steady ? 0 : pick_gap();
		fs_eff = fs | reads_blank(fs);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.gray <= g;
		pix_ch.frame_start <= fs_eff;
		do @(posedge clk); while (!pix_ch.ready);
		d = diffuse_pixel(g, fs_eff);
		expected_dots.insert(expected_dots.size(), d);
		n_pixels++;
		if (fs_eff) begin
			n_frames++;
		end
		@(negedge clk);
	endtask

	task automatic settle();
		pix_ch.valid <= 1'b0;
		wait (expected_dots.size() == 0);
		@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input fsd_pkg::cfg_idx_t idx, input int val);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= CFG_W'(val);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			fsd_pkg::CFG_LINE_WIDTH: begin
				width_reg = CFG_W'(val);
			end
			fsd_pkg::CFG_THRESHOLD: begin
				thresh_reg = GRAY_W'(val);
			end
		endcase
		n_cfg++;
	endtask

	task automatic test_defaults();
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd128, 1'b0);
		send_pixel(8'd127, 1'b0);
	endtask

	task automatic test_degenerate_widths();
		write_reg(fsd_pkg::CFG_LINE_WIDTH, 0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd200, 1'b0);
		write_reg(fsd_pkg::CFG_LINE_WIDTH, 1);
		send_pixel(8'd100, 1'b1);
		send_pixel(8'd140, 1'b0);
		write_reg(fsd_pkg::CFG_LINE_WIDTH, 2);
		send_pixel(8'd90, 1'b1);
		send_pixel(8'd170, 1'b0);
		send_pixel(8'd30, 1'b0);
		send_pixel(8'd220, 1'b0);
	endtask

	task automatic test_threshold_extremes();
		write_reg(fsd_pkg::CFG_THRESHOLD, 0);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		write_reg(fsd_pkg::CFG_THRESHOLD, 255);
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd254, 1'b0);
		send_pixel(8'd255, 1'b0);
	endtask

	// Shrinking the width past the current column ends the row at once and
	// reads an entry left over from the wider row.
	task automatic test_width_shrink();
		write_reg(fsd_pkg::CFG_LINE_WIDTH, 4);
		write_reg(fsd_pkg::CFG_THRESHOLD, 128);
		send_pixel(8'd200, 1'b1);
		send_pixel(8'd60, 1'b0);
		send_pixel(8'd130, 1'b0);
		send_pixel(8'd10, 1'b0);
		send_pixel(8'd90, 1'b0);
		send_pixel(8'd250, 1'b0);
		send_pixel(8'd3, 1'b0);
		write_reg(fsd_pkg::CFG_LINE_WIDTH, 2);
		send_pixel(8'd77, 1'b0);
	endtask

	task automatic test_random_stream(input int target);
		int sent;
		int span;
		int mode;
		int phase;
		int r;
		int i;
		logic [GRAY_W-1:0] g;
		logic fs;
		sent = 0;
		phase = 0;
		g = 8'd128;
		while (sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				write_reg(fsd_pkg::CFG_LINE_WIDTH, 0);
			end else if (r < 16) begin
				write_reg(fsd_pkg::CFG_LINE_WIDTH, 1);
			end else if (r < 24) begin
				write_reg(fsd_pkg::CFG_LINE_WIDTH, 2);
			end else begin
				write_reg(fsd_pkg::CFG_LINE_WIDTH, $urandom_range(3, 40));
			end
			r = $urandom_range(0, 99);
			if (r < 15) begin
				write_reg(fsd_pkg::CFG_THRESHOLD, 0);
			end else if (r < 30) begin
				write_reg(fsd_pkg::CFG_THRESHOLD, 255);
			end else begin
				write_reg(fsd_pkg::CFG_THRESHOLD, $urandom_range(0, 255));
			end
			mode = $urandom_range(0, 3);
			src_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			span = $urandom_range(30, 70);
			for (i = 0; i < span; i++) begin
				if (i == 0) begin
					fs = ($urandom_range(0, 9) < 7);
				end else if (col_q == 0 && $urandom_range(0, 9) == 0) begin
					fs = 1'b1;
				end else begin
					fs = ($urandom_range(0, 99) < 2);
				end
				if (phase == 0 && i == span / 2) begin
					settle();
				end
				g = pick_gray(mode, g);
				send_pixel(g, fs);
			end
			sent += span;
			phase++;
		end
		src_steady = 1'b0;
		sink_steady = 1'b0;
	endtask

	task automatic test_full_width();
		int i;
		logic [GRAY_W-1:0] g;
		g = 8'd100;
		write_reg(fsd_pkg::CFG_LINE_WIDTH, 2047);
		write_reg(fsd_pkg::CFG_THRESHOLD, $urandom_range(1, 254));
		for (i = 0; i < DEPTH + 24; i++) begin
			g = pick_gray(($urandom_range(0, 3) == 0) ? 0 : 1, g);
			send_pixel(g, i == 0);
		end
		write_reg(fsd_pkg::CFG_LINE_WIDTH, DEPTH);
		for (i = 0; i < 24; i++) begin
			g = pick_gray(0, g);
			send_pixel(g, 1'b0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = fsd_pkg::CFG_LINE_WIDTH;
		cfg_wr_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.gray = '0;
		pix_ch.frame_start = 1'b0;
		res_ch.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_defaults();
		test_degenerate_widths();
		test_threshold_extremes();
		test_width_shrink();
		test_random_stream(220);
		test_full_width();

		pix_ch.valid <= 1'b0;
		wait (expected_dots.size() == 0);
		repeat (10) @(posedge clk);

		$display("%0d pixels in %0d frame starts, %0d results checked, %0d register writes",
			n_pixels, n_frames, n_results, n_cfg);
		$display("widths 0 to 2047 incl. mid-row changes, thresholds 0 and 255, random stalls");
		if (faults == 0 && expected_dots.size() == 0) begin
			$display("floyd_steinberg_dither_tb: clean");
		end else begin
			$display("%0d mismatches", faults);
			$display("floyd_steinberg_dither_tb: errors");
		end
		$finish;
	end

endmodule

>>> floyd_steinberg_dither.f
rtl/fsd_pkg.sv
rtl/fsd_pix_if.sv
rtl/fsd_res_if.sv
rtl/fsd_ram.sv
rtl/fsd_line_store.sv
rtl/fsd_diffuse.sv
rtl/floyd_steinberg_dither.sv
sim/floyd_steinberg_dither_tb.sv
